>>> rtl/ocs_pkg.sv
`timescale 1ns / 1ps

package ocs_pkg;

   localparam int AXES        = 6;
   localparam int RAW_W       = 16;
   localparam int FILT_W      = 26;
   localparam int OFF_W       = 25;
   localparam int WEIGHT_W    = 16;
   localparam int FRAC_SHIFT  = 16;
   localparam int SAMPLE_W    = RAW_W + 8;
   localparam int DIFF_W      = FILT_W;
   localparam int COEF_W      = WEIGHT_W + 2;
   localparam int ACC_W       = FILT_W + COEF_W;
   localparam int SHIFTED_W   = ACC_W - FRAC_SHIFT;

   localparam int CAL_SAMPLES = 1024;
   localparam int CAL_SHIFT   = $clog2(CAL_SAMPLES + 1) - 1;
   localparam int CNT_W       = $clog2(CAL_SAMPLES + 1);
   localparam int SUM_W       = FILT_W + $clog2(CAL_SAMPLES);

   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd49152;
   localparam logic [COEF_W-1:0]   WEIGHT_ONE   = COEF_W'(1 << FRAC_SHIFT);

   localparam logic signed [FILT_W-1:0] FILT_MAX = {1'b0, {(FILT_W-1){1'b1}}};
   localparam logic signed [FILT_W-1:0] FILT_MIN = {1'b1, {(FILT_W-1){1'b0}}};

   localparam int REQ_DATA_W = AXES * RAW_W;
   localparam int RSP_DATA_W = ((AXES * FILT_W + 7) / 8) * 8;

   typedef enum logic {
      PHASE_CAL,
      PHASE_RUN
   } phase_type;

   typedef struct packed {
      logic step;
      logic running;
   } cal_ctrl_type;

endpackage

>>> rtl/six_axis_offset_calibrated_smoother_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  req_tdata: six raw axes, 16 b each
// rsp       out        rsp_tvalid/rsp_tready  rsp_tdata: six filtered axes, 26 b; tuser: phase
// csr       in         csr_wr_en              csr_wr_data: smoothing weight
//
// One beat accepted per cycle while req_tready is high; a beat passes from input register to result register.
// The per-axis filter update sits between those registers and sets the cycle time.
// Reset restarts calibration; the weight returns to 49152.
// A stalled result holds in the result register while the input register still takes a beat;
// req_tready drops only when both are full and rsp_tready is low.

module six_axis_offset_calibrated_smoother_unit
   import ocs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
   input  logic [REQ_DATA_W-1:0] req_tdata,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // accel_x_filtered, accel_y_filtered, accel_z_filtered,
   // gyro_x_filtered, gyro_y_filtered, gyro_z_filtered, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // phase
   output logic                  rsp_tuser,

   input  logic                  csr_wr_en,
   input  logic [WEIGHT_W-1:0]   csr_wr_data
);

   logic                  in_valid_ff;
   logic [REQ_DATA_W-1:0] in_data_ff;
   logic                  out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic                  out_phase_ff;
   logic [WEIGHT_W-1:0]   weight_ff;
   logic                  advance;
   cal_ctrl_type          ctrl;

   logic signed [FILT_W-1:0] filt [AXES];

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_phase_ff;

   ocs_cal_ctrl u_cal_ctrl (
      .clock  (clock),
      .reset  (reset),
      .step_i (advance),
      .ctrl_o (ctrl)
   );

   for (genvar i = 0; i < AXES; i++) begin : g_lane
      ocs_axis_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl_i   (ctrl),
         .weight_i (weight_ff),
         .raw_i    (signed'(in_data_ff[i*RAW_W +: RAW_W])),
         .filt_o   (filt[i])
      );
   end

   always_comb begin
      out_data_in = '0;
      for (int i = 0; i < AXES; i++) begin
         out_data_in[i*FILT_W +: FILT_W] = filt[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= WEIGHT_RESET;
      end else if (csr_wr_en) begin
         weight_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff  <= out_data_in;
         out_phase_ff <= ctrl.running;
      end
   end

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("input stage empty but not ready");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("processed beat lost before result register");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("waiting input beat dropped or overwritten");

endmodule

>>> rtl/ocs_cal_ctrl.sv
`timescale 1ns / 1ps

module ocs_cal_ctrl
   import ocs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step_i,
   output cal_ctrl_type ctrl_o
);

   phase_type          phase_ff, phase_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      case (phase_ff)
         PHASE_CAL: begin
            if (step_i) begin
               count_in = count_ff + CNT_W'(1);
               if (count_in == CNT_W'(CAL_SAMPLES)) begin
                  phase_in = PHASE_RUN;
               end
            end
         end
         PHASE_RUN: begin
            phase_in = PHASE_RUN;
         end
         default: begin
            phase_in = PHASE_CAL;
         end
      endcase
   end

   always_comb begin
      ctrl_o.step    = step_i;
      ctrl_o.running = (phase_ff == PHASE_RUN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_CAL;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   // run mode is left only through reset
   a_run_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PHASE_RUN) |=> (phase_ff == PHASE_RUN))
      else $error("calibration phase re-entered without reset");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAL_SAMPLES))
      else $error("calibration count past sample total");

   a_run_full: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PHASE_RUN) |-> (count_ff == CNT_W'(CAL_SAMPLES)))
      else $error("run mode entered before calibration completed");

endmodule

>>> rtl/ocs_axis_lane.sv
`timescale 1ns / 1ps

module ocs_axis_lane
   import ocs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cal_ctrl_type               ctrl_i,
   input  logic        [WEIGHT_W-1:0] weight_i,
   input  logic signed [RAW_W-1:0]    raw_i,
   output logic signed [FILT_W-1:0]   filt_o
);

   logic signed [FILT_W-1:0]    filt_ff, filt_in;
   logic signed [SUM_W-1:0]     sum_ff, sum_in;

   logic signed [SUM_W-1:0]     sum_shifted;
   logic signed [OFF_W-1:0]     offset;
   logic signed [SAMPLE_W-1:0]  sample;
   logic signed [DIFF_W-1:0]    diff;
   logic signed [COEF_W-1:0]    keep;
   logic signed [COEF_W-1:0]    gain;
   logic signed [ACC_W-1:0]     acc;
   logic signed [SHIFTED_W-1:0] shifted;

   always_comb begin
      // offset is the mean of the calibration sums; they freeze in run mode
      sum_shifted = sum_ff >>> CAL_SHIFT;
      offset      = ctrl_i.running ? sum_shifted[OFF_W-1:0] : '0;
      sample      = {raw_i, 8'h00};
      diff        = DIFF_W'(sample) - DIFF_W'(offset);
      keep        = signed'({2'b00, weight_i});
      gain        = signed'(WEIGHT_ONE - COEF_W'(weight_i));
      acc         = (ACC_W'(filt_ff) * ACC_W'(keep)) + (ACC_W'(diff) * ACC_W'(gain));
      shifted     = acc[ACC_W-1:FRAC_SHIFT];
      if (shifted > SHIFTED_W'(FILT_MAX)) begin
         filt_in = FILT_MAX;
      end else if (shifted < SHIFTED_W'(FILT_MIN)) begin
         filt_in = FILT_MIN;
      end else begin
         filt_in = shifted[FILT_W-1:0];
      end
      sum_in = sum_ff + SUM_W'(filt_in);
   end

   assign filt_o = filt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff <= '0;
         sum_ff  <= '0;
      end else if (ctrl_i.step) begin
         filt_ff <= filt_in;
         if (!ctrl_i.running) begin
            sum_ff <= sum_in;
         end
      end
   end

   a_sum_frozen: assert property (@(posedge clock) disable iff (reset)
      ctrl_i.running |=> $stable(sum_ff))
      else $error("calibration sum moved in run mode");

   a_filt_hold: assert property (@(posedge clock) disable iff (reset)
      !ctrl_i.step |=> $stable(filt_ff))
      else $error("filter state changed without an item");

endmodule

>>> tb/six_axis_offset_calibrated_smoother_unit_test.sv
`timescale 1ns / 1ps

module six_axis_offset_calibrated_smoother_unit_test;
   import ocs_pkg::*;

   localparam int LATENCY     = 2;
   localparam int STALL_LIMIT = 4000;
   localparam int LOG2_CAL    = $clog2(CAL_SAMPLES + 1) - 1;

   typedef logic [AXES-1:0][RAW_W-1:0] raw_axes_type;

   typedef struct packed {
      logic [RSP_DATA_W-1:0] data;
      phase_type             phase;
   } filtered_beat_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_wr_en   = 1'b0;
   logic [WEIGHT_W-1:0]   csr_wr_data = '0;

   // Filter model: own copy of weight, filter state, offsets and calibration sums
   logic [WEIGHT_W-1:0] weight_model  = WEIGHT_RESET;
   longint              filt_model[AXES]   = '{default: 0};
   longint              offset_model[AXES] = '{default: 0};
   longint              cal_sum[AXES]      = '{default: 0};
   int                  cal_seen      = 0;
   bit                  running       = 1'b0;

   filtered_beat_type expected_filtered[$];
   int             error_count    = 0;
   int             stalled_cycles = 0;
   bit             no_idle        = 1'b0;
   int             axis_bias[AXES];

   string axis_name[AXES] = '{"accel_x", "accel_y", "accel_z", "gyro_x", "gyro_y", "gyro_z"};

   six_axis_offset_calibrated_smoother_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic filtered_beat_type filter_update(logic [REQ_DATA_W-1:0] raw);
      filtered_beat_type beat;
      longint         k;
      longint         sample;
      longint         off;
      longint         acc;
      longint         v;
      k = longint'(weight_model);
      beat.data = '0;
      beat.phase = running ? PHASE_RUN : PHASE_CAL;
      for (int i = 0; i < AXES; i++) begin
         sample = longint'($signed(raw[i*RAW_W +: RAW_W])) * 256;
         off = running ? offset_model[i] : 0;
         acc = k * filt_model[i] + (65536 - k) * (sample - off);
         v = acc >>> 16;
         if (v > longint'(FILT_MAX)) v = longint'(FILT_MAX);
         if (v < longint'(FILT_MIN)) v = longint'(FILT_MIN);
         filt_model[i] = v;
         if (!running) cal_sum[i] += v;
         beat.data[i*FILT_W +: FILT_W] = v[FILT_W-1:0];
      end
      if (!running) begin
         cal_seen++;
         // last calibration beat: latch offsets, later beats run corrected
         if (cal_seen >= CAL_SAMPLES) begin
            for (int i = 0; i < AXES; i++) offset_model[i] = cal_sum[i] >>> LOG2_CAL;
            running = 1'b1;
         end
      end
      return beat;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d, want %0d", what, got, want);
      error_count++;
   endtask

   task automatic check_result();
      filtered_beat_type want;
      longint         got_axis;
      longint         want_axis;
      if (expected_filtered.size() == 0) begin
         report_mismatch("beat with nothing pending", 0, 0);
         return;
      end
      want = expected_filtered.pop_front();
      for (int i = 0; i < AXES; i++) begin
         got_axis  = longint'($signed(rsp_tdata[i*FILT_W +: FILT_W]));
         want_axis = longint'($signed(want.data[i*FILT_W +: FILT_W]));
         if (rsp_tdata[i*FILT_W +: FILT_W] !== want.data[i*FILT_W +: FILT_W])
            report_mismatch({axis_name[i], "_filtered"}, got_axis, want_axis);
      end
      if (rsp_tdata[RSP_DATA_W-1:AXES*FILT_W] !== '0)
         report_mismatch("tdata zero fill", longint'(rsp_tdata[RSP_DATA_W-1:AXES*FILT_W]), 0);
      if (rsp_tuser !== want.phase)
         report_mismatch("phase", longint'(rsp_tuser), longint'(want.phase));
   endtask

   // Result side: check each beat, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result();
      rsp_tready <= no_idle || ($urandom_range(0, 99) >= 34);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("[six_axis_offset_calibrated_smoother_unit] ERROR");
         $finish;
      end
   end

   // Leaves req_tvalid high after the accepting edge; the next call may lower it for a random gap
   task automatic send_sample(raw_axes_type samples);
      while (!no_idle && $urandom_range(0, 99) < 34) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= samples;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_filtered.push_back(filter_update(samples));
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (expected_filtered.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_weight(logic [WEIGHT_W-1:0] w);
      drain_pipeline();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      weight_model  = w;
   endtask

   function automatic raw_axes_type all_axes(logic [RAW_W-1:0] v);
      return {AXES{v}};
   endfunction

   function automatic logic [RAW_W-1:0] extreme_or_random();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return RAW_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [RAW_W-1:0] near_bias(int bias, int spread);
      int v;
      v = bias + int'($urandom_range(0, 2 * spread)) - spread;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[RAW_W-1:0];
   endfunction

   // Mostly a sensor at rest around its bias, the rest noise and extremes
   function automatic raw_axes_type sensor_sample(int noise_pct);
      raw_axes_type s;
      bit        wild;
      wild = ($urandom_range(0, 99) < noise_pct);
      for (int i = 0; i < AXES; i++)
         s[i] = (wild && $urandom_range(0, 1)) ? extreme_or_random()
                                                : near_bias(axis_bias[i], 200);
      return s;
   endfunction

   task automatic test_directed_extremes();
      raw_axes_type alt;
      alt = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
      // reset weight
      send_sample(all_axes(16'h7FFF));
      send_sample(all_axes(16'h8000));
      send_sample(all_axes(16'h0000));
      send_sample(all_axes(16'hFFFF));
      send_sample(alt);
      send_sample(~alt);
      send_sample(all_axes(16'h0001));
      send_sample(all_axes(16'hAAAA));
      // zero weight: output follows the sample exactly
      write_weight(16'd0);
      send_sample(all_axes(16'h7FFF));
      send_sample(all_axes(16'h8000));
      send_sample(all_axes(16'hFFFF));
      send_sample(all_axes(16'h0000));
      send_sample(alt);
      // full weight: output barely moves
      write_weight(16'hFFFF);
      send_sample(all_axes(16'h7FFF));
      send_sample(all_axes(16'h7FFF));
      send_sample(all_axes(16'h8000));
      send_sample(all_axes(16'h8000));
      send_sample(~alt);
   endtask

   task automatic test_calibration();
      logic [WEIGHT_W-1:0] weights[4];
      weights = '{WEIGHT_RESET, WEIGHT_W'($urandom_range(0, 65535)), 16'd1, 16'hFFFE};
      for (int i = 0; i < AXES; i++)
         axis_bias[i] = (i < 3) ? int'($urandom_range(0, 24000)) - 12000
                                : int'($urandom_range(0, 6000)) - 3000;
      for (int p = 0; p < 4; p++) begin
         write_weight(weights[p]);
         while (cal_seen < (p + 1) * (CAL_SAMPLES / 4)) send_sample(sensor_sample(10));
      end
   endtask

   task automatic test_run_mode();
      logic [WEIGHT_W-1:0] weights[5];
      int                  counts[5];
      raw_axes_type        alt;
      alt = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
      weights = '{16'd0, 16'hFFFF, WEIGHT_W'($urandom_range(0, 65535)), WEIGHT_RESET,
                  WEIGHT_W'($urandom_range(1, 255))};
      counts  = '{20, 20, 50, 20, 20};
      // offsets now applied: extremes again
      send_sample(all_axes(16'h7FFF));
      send_sample(all_axes(16'h8000));
      send_sample(alt);
      send_sample(all_axes(16'h0000));
      send_sample(all_axes(16'hFFFF));
      for (int p = 0; p < 5; p++) begin
         write_weight(weights[p]);
         // hold both sides busy through one whole phase
         no_idle = (p == 2);
         repeat (counts[p]) send_sample(sensor_sample(30));
         no_idle = 1'b0;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_calibration();
      test_run_mode();
      drain_pipeline();
      if (error_count == 0 && expected_filtered.size() == 0)
         $display("[six_axis_offset_calibrated_smoother_unit] OK");
      else
         $display("[six_axis_offset_calibrated_smoother_unit] ERROR");
      $finish;
   end

endmodule
